// ----- rtl/flg_pkg.sv -----
// Shared types, constants and helper functions for the stereo flanger.
package flg_pkg;

  localparam int DelayDepthDefault = 512;
  localparam int SampleRateDefault = 48000;

  localparam int DataW    = 24;
  localparam int RateW    = 14;
  localparam int CtlW     = 16;
  localparam int PhaseW   = 32;
  localparam int DelayW   = 26;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;
  localparam int QueueDepth = 2;

  localparam logic [RateW-1:0] RateMin = 14'd10;
  localparam logic [RateW-1:0] RateMax = 14'd10000;
  localparam logic [CtlW-1:0] UnityQ15 = 16'h8000;
  localparam logic signed [CtlW-1:0] FbMax = 16'sd31130;
  localparam logic signed [CtlW-1:0] FbMin = -16'sd31130;
  localparam logic signed [17:0] WetGain = 18'sd23170;

  localparam logic [15:0] CoeffReset = 16'd679;
  localparam logic [6:0] MinDelayReset = 7'd24;
  localparam logic [8:0] MaxSweepReset = 9'd360;
  localparam logic [DelayW-1:0] DelayReset = 26'd6291456;

  localparam logic [15:0] QuarterSine [0:32] = '{
    16'd0, 16'd1608, 16'd3212, 16'd4808, 16'd6393, 16'd7962, 16'd9512, 16'd11039,
    16'd12539, 16'd14010, 16'd15446, 16'd16846, 16'd18204, 16'd19519, 16'd20787,
    16'd22005, 16'd23170, 16'd24279, 16'd25329, 16'd26319, 16'd27245, 16'd28105,
    16'd28898, 16'd29621, 16'd30273, 16'd30852, 16'd31356, 16'd31785, 16'd32137,
    16'd32412, 16'd32609, 16'd32728, 16'd32767};

  typedef enum logic [CfgIdxW-1:0] {
    CFG_COEFF     = 2'd0,
    CFG_MIN_DELAY = 2'd1,
    CFG_MAX_SWEEP = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic signed [DataW-1:0] left_in;
    logic signed [DataW-1:0] right_in;
    logic [RateW-1:0]        lfo_rate;
    logic [CtlW-1:0]         sweep_depth;
    logic signed [CtlW-1:0]  feedback_gain;
    logic [CtlW-1:0]         wet_blend;
  } in_t;

  typedef struct packed {
    logic signed [DataW-1:0] left_out;
    logic signed [DataW-1:0] right_out;
  } out_t;

  typedef struct packed {
    logic signed [DataW-1:0] dry_l;
    logic signed [DataW-1:0] dry_r;
    logic [PhaseW-1:0]       phase_inc;
    logic [CtlW-1:0]         depth;
    logic signed [CtlW-1:0]  fb;
    logic [CtlW-1:0]         mix;
  } work_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_t;

  typedef enum logic [4:0] {
    S_IDLE, S_SIN, S_DS, S_TL, S_TG, S_SD, S_ADR, S_ADB, S_IL, S_IR,
    S_FL, S_FR, S_WL, S_WR, S_ML, S_MR, S_OR, S_DONE
  } core_state_t;

  function automatic logic [15:0] quarter_sine(input logic [5:0] idx);
    logic [15:0] v;
    if (idx > 6'd32) begin
      v = QuarterSine[32];
    end else begin
      v = QuarterSine[idx];
    end
    return v;
  endfunction

  function automatic logic signed [DataW-1:0] sat24(input logic signed [27:0] x);
    logic signed [DataW-1:0] v;
    if (x > 28'sd8388607) begin
      v = 24'sh7FFFFF;
    end else if (x < -28'sd8388608) begin
      v = 24'sh800000;
    end else begin
      v = x[DataW-1:0];
    end
    return v;
  endfunction

endpackage

// ----- rtl/flg_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module flg_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/flg_queue.sv -----
// Two-entry queue that carries clamped work items from the front end to the core.
module flg_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  flg_pkg::work_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output flg_pkg::work_t head
);

  flg_pkg::work_t entries [flg_pkg::QueueDepth];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full  = (count == 2'(flg_pkg::QueueDepth));
  assign valid = (count != 2'd0);
  assign head  = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("Queue written while full.");
  assert property (@(posedge clk) disable iff (rst) pop |-> count != 2'd0)
    else $error("Queue read while empty.");
  assert property (@(posedge clk) disable iff (rst) count <= 2'(flg_pkg::QueueDepth))
    else $error("Queue count beyond its depth.");

endmodule

// ----- rtl/flg_front.sv -----
// Front end: accepts input transactions, clamps controls and derives the phase increment.
module flg_front #(
  parameter int SAMPLE_RATE = flg_pkg::SampleRateDefault
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  flg_pkg::in_t   in_data,
  output logic           push,
  output flg_pkg::work_t push_data,
  input  logic           full
);

  // Phase increment is floor(rate * 2^32 / (1000 * SAMPLE_RATE)), formed as a
  // multiplication by a rounded-up reciprocal that is exact for every 14-bit rate.
  localparam int PhW = flg_pkg::PhaseW;
  localparam int RecipShift = 42;
  localparam logic [79:0] DivC = 80'(1000 * SAMPLE_RATE);
  localparam logic [79:0] Recip = ((80'd1 << (PhW + RecipShift)) + DivC - 80'd1) / DivC;
  localparam logic [25:0] RecipLo = Recip[25:0];
  localparam logic [25:0] RecipHi = Recip[51:26];
  localparam int DivCycles = 2;
  localparam int CntW = $clog2(DivCycles);
  localparam logic [CntW-1:0] CntLast = CntW'(DivCycles - 1);

  flg_pkg::front_state_t state, state_next;
  flg_pkg::work_t item;
  logic [flg_pkg::RateW-1:0] rate;
  logic [39:0] part;
  logic [39:0] lo_prod;
  logic [CntW-1:0] cnt;

  logic [flg_pkg::RateW-1:0] rate_c;
  logic [flg_pkg::CtlW-1:0] depth_c, mix_c;
  logic signed [flg_pkg::CtlW-1:0] fb_c;
  logic accept;

  assign part = 40'(rate) * 40'((cnt == CntLast) ? RecipHi : RecipLo);

  always_comb begin
    rate_c = in_data.lfo_rate;
    if (rate_c < flg_pkg::RateMin) begin
      rate_c = flg_pkg::RateMin;
    end else if (rate_c > flg_pkg::RateMax) begin
      rate_c = flg_pkg::RateMax;
    end
    depth_c = (in_data.sweep_depth > flg_pkg::UnityQ15) ? flg_pkg::UnityQ15
                                                         : in_data.sweep_depth;
    mix_c = (in_data.wet_blend > flg_pkg::UnityQ15) ? flg_pkg::UnityQ15 : in_data.wet_blend;
    fb_c = in_data.feedback_gain;
    if (fb_c > flg_pkg::FbMax) begin
      fb_c = flg_pkg::FbMax;
    end else if (fb_c < flg_pkg::FbMin) begin
      fb_c = flg_pkg::FbMin;
    end
  end

  assign accept    = in_valid && in_ready;
  assign push_data = item;

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    push       = 1'b0;
    unique case (state)
      flg_pkg::F_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = flg_pkg::F_DIV;
        end
      end
      flg_pkg::F_DIV: begin
        if (cnt == CntLast) begin
          state_next = flg_pkg::F_PUSH;
        end
      end
      flg_pkg::F_PUSH: begin
        if (!full) begin
          push       = 1'b1;
          state_next = flg_pkg::F_IDLE;
        end
      end
      default: state_next = flg_pkg::F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= flg_pkg::F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.dry_l <= in_data.left_in;
      item.dry_r <= in_data.right_in;
      item.depth <= depth_c;
      item.fb    <= fb_c;
      item.mix   <= mix_c;
      rate       <= rate_c;
      cnt        <= '0;
    end else if (state == flg_pkg::F_DIV) begin
      if (cnt == CntLast) begin
        item.phase_inc <= PhW'(({part, 26'b0} + 66'(lo_prod)) >> RecipShift);
      end else begin
        lo_prod <= part;
      end
      cnt <= cnt + 1'b1;
    end
  end

endmodule

// ----- rtl/flg_core.sv -----
// Core sequencer: LFO, delay smoothing, interpolated delay taps, feedback and mix.
module flg_core #(
  parameter int DELAY_DEPTH = flg_pkg::DelayDepthDefault
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [flg_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [flg_pkg::CfgDataW-1:0] cfg_data,
  input  logic                         q_valid,
  input  flg_pkg::work_t               q_data,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output flg_pkg::out_t                out_data
);

  localparam int AW = $clog2(DELAY_DEPTH);
  localparam logic [AW:0] DepthC = (AW + 1)'(DELAY_DEPTH);
  localparam logic [AW-1:0] LastAddr = AW'(DELAY_DEPTH - 1);
  localparam logic [AW-1:0] MaxTap = AW'(DELAY_DEPTH - 2);
  localparam logic [12:0] MaxTapW = 13'(DELAY_DEPTH - 2);

  flg_pkg::core_state_t state, state_next;
  flg_pkg::work_t cur;

  logic [15:0] coeff;
  logic [6:0]  min_delay;
  logic [8:0]  max_sweep;

  logic [flg_pkg::PhaseW-1:0] phase;
  logic [flg_pkg::DelayW-1:0] sd;
  logic [AW-1:0] wp;
  logic          wrapped;

  logic signed [26:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [44:0] prod;

  logic [15:0] sine_a;
  logic        neg;
  logic [15:0] lfo;
  logic [AW-1:0] n;
  logic [AW-1:0] ia;
  logic [15:0] f;
  logic a_ok, b_ok;
  logic signed [23:0] a_l, a_r, b_r, del_l, del_r, wr_l, out_l, out_r;
  logic signed [27:0] wet_l, wet_r;

  logic ram_we;
  logic [AW-1:0] ram_raddr;
  logic [23:0] rdata_l, rdata_r;

  logic [1:0]  quad;
  logic [30:0] pos;
  logic [5:0]  sidx;
  logic [15:0] sfrac, ta, tb;
  logic signed [16:0] tdiff, sv, sv_n;
  logic signed [17:0] lsum;
  logic signed [27:0] rnd16, rnd15;
  logic [flg_pkg::DelayW-1:0] target_c;
  logic signed [26:0] diff_c;
  logic signed [27:0] sd_sum;
  logic [9:0]  ip;
  logic [12:0] ip_w;
  logic [AW-1:0] n_c, ia_c, ib_c;
  logic [15:0] f_c;
  logic [AW:0] ia_w;
  logic signed [23:0] b_l_c, b_r_c, wr_r_c;
  logic emit;

  // Sine from the quarter-wave table.
  assign quad  = phase[31:30];
  assign pos   = quad[0] ? (31'h40000000 - {1'b0, phase[29:0]}) : {1'b0, phase[29:0]};
  assign sidx  = pos[30:25];
  assign sfrac = pos[24:9];
  assign ta    = flg_pkg::quarter_sine(sidx);
  assign tb    = flg_pkg::quarter_sine(sidx + 6'd1);
  assign tdiff = $signed({1'b0, tb}) - $signed({1'b0, ta});
  assign sv    = $signed({1'b0, sine_a}) + 17'(prod >>> 16);
  assign sv_n  = neg ? -sv : sv;
  assign lsum  = 18'(sv_n) + 18'sd32768;

  assign rnd16 = 28'((prod + 45'sd32768) >>> 16);
  assign rnd15 = 28'((prod + 45'sd16384) >>> 15);

  assign target_c = {3'b0, min_delay, 16'b0} + prod[40:15];
  assign diff_c   = $signed({1'b0, target_c}) - $signed({1'b0, sd});
  assign sd_sum   = $signed({2'b0, sd}) + rnd16;

  // Read delay clamped to one sample below and two samples short of the buffer above.
  assign ip   = sd[25:16];
  assign ip_w = {3'b0, ip};
  always_comb begin
    if (ip == 10'd0) begin
      n_c = AW'(1);
      f_c = '0;
    end else if (ip_w > MaxTapW || (ip_w == MaxTapW && sd[15:0] != 16'd0)) begin
      n_c = MaxTap;
      f_c = '0;
    end else begin
      n_c = AW'(ip_w);
      f_c = sd[15:0];
    end
  end

  assign ia_w = (wp >= n_c) ? ({1'b0, wp} - {1'b0, n_c})
                            : ({1'b0, wp} + DepthC - {1'b0, n_c});
  assign ia_c = ia_w[AW-1:0];
  assign ib_c = (ia == '0) ? LastAddr : ia - 1'b1;

  assign b_l_c  = b_ok ? $signed(rdata_l) : 24'sd0;
  assign b_r_c  = b_ok ? $signed(rdata_r) : 24'sd0;
  assign wr_r_c = flg_pkg::sat24(28'(cur.dry_r) + rnd15);

  assign emit = (state == flg_pkg::S_DONE) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    ram_we     = 1'b0;
    ram_raddr  = ia;
    unique case (state)
      flg_pkg::S_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = flg_pkg::S_SIN;
        end
      end
      flg_pkg::S_SIN: begin
        mul_a      = 27'(tdiff);
        mul_b      = $signed({2'b0, sfrac});
        state_next = flg_pkg::S_DS;
      end
      flg_pkg::S_DS: begin
        mul_a      = $signed({11'b0, cur.depth});
        mul_b      = $signed({9'b0, max_sweep});
        state_next = flg_pkg::S_TL;
      end
      flg_pkg::S_TL: begin
        mul_a      = $signed({2'b0, prod[24:0]});
        mul_b      = $signed({2'b0, lfo});
        state_next = flg_pkg::S_TG;
      end
      flg_pkg::S_TG: begin
        mul_a      = diff_c;
        mul_b      = $signed({2'b0, coeff});
        state_next = flg_pkg::S_SD;
      end
      flg_pkg::S_SD: begin
        state_next = flg_pkg::S_ADR;
      end
      flg_pkg::S_ADR: begin
        ram_raddr  = ia_c;
        state_next = flg_pkg::S_ADB;
      end
      flg_pkg::S_ADB: begin
        ram_raddr  = ib_c;
        state_next = flg_pkg::S_IL;
      end
      flg_pkg::S_IL: begin
        mul_a      = 27'(b_l_c) - 27'(a_l);
        mul_b      = $signed({2'b0, f});
        state_next = flg_pkg::S_IR;
      end
      flg_pkg::S_IR: begin
        mul_a      = 27'(b_r) - 27'(a_r);
        mul_b      = $signed({2'b0, f});
        state_next = flg_pkg::S_FL;
      end
      flg_pkg::S_FL: begin
        mul_a      = 27'(del_l);
        mul_b      = 18'(cur.fb);
        state_next = flg_pkg::S_FR;
      end
      flg_pkg::S_FR: begin
        mul_a      = 27'(del_r);
        mul_b      = 18'(cur.fb);
        state_next = flg_pkg::S_WL;
      end
      flg_pkg::S_WL: begin
        ram_we     = 1'b1;
        mul_a      = 27'(cur.dry_l) + 27'(del_l);
        mul_b      = flg_pkg::WetGain;
        state_next = flg_pkg::S_WR;
      end
      flg_pkg::S_WR: begin
        mul_a      = 27'(cur.dry_r) + 27'(del_r);
        mul_b      = flg_pkg::WetGain;
        state_next = flg_pkg::S_ML;
      end
      flg_pkg::S_ML: begin
        mul_a      = 27'(wet_l - 28'(cur.dry_l));
        mul_b      = $signed({2'b0, cur.mix});
        state_next = flg_pkg::S_MR;
      end
      flg_pkg::S_MR: begin
        mul_a      = 27'(wet_r - 28'(cur.dry_r));
        mul_b      = $signed({2'b0, cur.mix});
        state_next = flg_pkg::S_OR;
      end
      flg_pkg::S_OR: begin
        state_next = flg_pkg::S_DONE;
      end
      flg_pkg::S_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = flg_pkg::S_IDLE;
        end
      end
      default: state_next = flg_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= flg_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coeff     <= flg_pkg::CoeffReset;
      min_delay <= flg_pkg::MinDelayReset;
      max_sweep <= flg_pkg::MaxSweepReset;
    end else if (cfg_write) begin
      case (cfg_index)
        flg_pkg::CFG_COEFF:     coeff <= cfg_data;
        flg_pkg::CFG_MIN_DELAY: min_delay <= cfg_data[6:0];
        flg_pkg::CFG_MAX_SWEEP: max_sweep <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= '0;
      sd        <= flg_pkg::DelayReset;
      wp        <= '0;
      wrapped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (state == flg_pkg::S_IDLE && q_valid) begin
        phase <= phase + q_data.phase_inc;
      end
      if (state == flg_pkg::S_SD) begin
        sd <= sd_sum[flg_pkg::DelayW-1:0];
      end
      if (emit) begin
        out_valid <= 1'b1;
        if (wp == LastAddr) begin
          wp      <= '0;
          wrapped <= 1'b1;
        end else begin
          wp <= wp + 1'b1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    unique case (state)
      flg_pkg::S_IDLE: begin
        cur <= q_data;
      end
      flg_pkg::S_SIN: begin
        sine_a <= ta;
        neg    <= quad[1];
      end
      flg_pkg::S_DS: begin
        lfo <= lsum[15:0];
      end
      flg_pkg::S_ADR: begin
        n    <= n_c;
        f    <= f_c;
        ia   <= ia_c;
        a_ok <= wrapped || (ia_c < wp);
      end
      flg_pkg::S_ADB: begin
        b_ok <= wrapped || (ib_c < wp);
        a_l  <= a_ok ? $signed(rdata_l) : 24'sd0;
        a_r  <= a_ok ? $signed(rdata_r) : 24'sd0;
      end
      flg_pkg::S_IL: begin
        b_r <= b_r_c;
      end
      flg_pkg::S_IR: begin
        del_l <= a_l + 24'(rnd16);
      end
      flg_pkg::S_FL: begin
        del_r <= a_r + 24'(rnd16);
      end
      flg_pkg::S_FR: begin
        wr_l <= flg_pkg::sat24(28'(cur.dry_l) + rnd15);
      end
      flg_pkg::S_WR: begin
        wet_l <= rnd15;
      end
      flg_pkg::S_ML: begin
        wet_r <= rnd15;
      end
      flg_pkg::S_MR: begin
        out_l <= flg_pkg::sat24(28'(cur.dry_l) + rnd15);
      end
      flg_pkg::S_OR: begin
        out_r <= flg_pkg::sat24(28'(cur.dry_r) + rnd15);
      end
      flg_pkg::S_DONE: begin
        if (emit) begin
          out_data.left_out  <= out_l;
          out_data.right_out <= out_r;
        end
      end
      default: ;
    endcase
  end

  flg_ram #(.WIDTH(flg_pkg::DataW), .DEPTH(DELAY_DEPTH)) u_ram_l (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp),
    .wdata (wr_l),
    .raddr (ram_raddr),
    .rdata (rdata_l)
  );

  flg_ram #(.WIDTH(flg_pkg::DataW), .DEPTH(DELAY_DEPTH)) u_ram_r (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp),
    .wdata (wr_r_c),
    .raddr (ram_raddr),
    .rdata (rdata_r)
  );

  assert property (@(posedge clk) disable iff (rst) wrapped |=> wrapped)
    else $error("Delay memory fill flag cleared outside reset.");
  assert property (@(posedge clk) disable iff (rst)
    state == flg_pkg::S_ADB |-> (n >= AW'(1) && n <= MaxTap))
    else $error("Delay tap outside the buffer.");
  assert property (@(posedge clk) disable iff (rst) emit |=> wp != $past(wp))
    else $error("Write pointer did not advance with a result.");

endmodule

// ----- rtl/stereo_flanger.sv -----
// Top level of the stereo flanger: front end, work queue and processing core.
//
// Input transactions carry one stereo Q1.23 sample and its per-sample controls
// on in_data, accepted when in_valid and in_ready are both high. Each result
// transaction carries the mixed stereo sample on out_data under out_valid and
// out_ready. Configuration registers are written through cfg_write, cfg_index
// and cfg_data in a single cycle; they should only change while the block is idle.
// The front end clamps the controls and derives the LFO phase increment by a
// reciprocal multiplication in two passes, and takes no new sample until it has
// pushed the last one into the queue. The core runs one shared multiplier through
// 18 sequencer steps per transaction and starts the next one only after it has
// handed its result to the output register. A two-entry queue between the two
// halves lets the front end take new samples while the core works.
// When the receiver stalls, the finished result is held in the output register
// and the core waits; the queue and then in_ready back up behind it.
// Reset clears the LFO phase and write pointer, sets the delay smoother to its
// reset value and restores the register defaults. The delay memories need no
// clearing pass: locations not yet written since reset read as zero.
module stereo_flanger #(
  parameter int DELAY_DEPTH = flg_pkg::DelayDepthDefault,
  parameter int SAMPLE_RATE = flg_pkg::SampleRateDefault
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  flg_pkg::in_t                 in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output flg_pkg::out_t                out_data,
  input  logic                         cfg_write,
  input  logic [flg_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [flg_pkg::CfgDataW-1:0] cfg_data
);

  logic           push, full, pop, q_valid;
  flg_pkg::work_t push_data, head;

  flg_front #(.SAMPLE_RATE(SAMPLE_RATE)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  flg_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .valid     (q_valid),
    .head      (head)
  );

  flg_core #(.DELAY_DEPTH(DELAY_DEPTH)) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_data    (head),
    .q_pop     (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- tb/sv/stereo_flanger_test.sv -----
// Self-checking testbench for stereo_flanger with a built-in bit-exact flanger predictor.
`timescale 1ns / 100ps

module stereo_flanger_test;

  localparam int InW = $bits(flg_pkg::in_t);

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  flg_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  flg_pkg::out_t out_data;
  logic cfg_write = 1'b0;
  logic [flg_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [flg_pkg::CfgDataW-1:0] cfg_data = '0;

  stereo_flanger dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  longint mem_l [0:511];
  longint mem_r [0:511];
  int unsigned wr_ptr;
  logic [31:0] phase_acc;
  longint smooth_dly;
  longint coeff_reg, min_dly_reg, sweep_reg;

  flg_pkg::out_t expected_mix [$];
  int mismatches = 0;
  int send_idle_pct = 38;
  int recv_idle_pct = 38;
  logic holding = 1'b0;
  event hold_go;

  function automatic longint rshift_round(longint x, int n);
    return (x + (longint'(1) << (n - 1))) >>> n;
  endfunction

  function automatic longint clamp24(longint x);
    if (x > 8388607) return 8388607;
    if (x < -8388608) return -8388608;
    return x;
  endfunction

  function automatic longint lfo_sine(logic [31:0] ph);
    logic [31:0] q, pos;
    int unsigned idx;
    longint frac, a, b, s;
    q = {2'b00, ph[29:0]};
    pos = ph[30] ? (32'h4000_0000 - q) : q;
    idx = pos >> 25;
    frac = longint'((pos >> 9) & 32'hFFFF);
    if (idx >= 32) begin
      s = longint'(flg_pkg::QuarterSine[32]);
    end else begin
      a = longint'(flg_pkg::QuarterSine[idx]);
      b = longint'(flg_pkg::QuarterSine[idx + 1]);
      s = a + (((b - a) * frac) >>> 16);
    end
    return ph[31] ? -s : s;
  endfunction

  function automatic longint tap_read(bit right, int unsigned n, longint f);
    longint a, b;
    int unsigned ia, ib;
    ia = (wr_ptr - n) & 511;
    ib = (wr_ptr - n - 1) & 511;
    a = right ? mem_r[ia] : mem_l[ia];
    b = right ? mem_r[ib] : mem_l[ib];
    return a + rshift_round((b - a) * f, 16);
  endfunction

  function automatic flg_pkg::out_t flange_sample(flg_pkg::in_t s);
    longint dl, dr, rate, depth, fb, mix, lfo, target, rd, f, yl, yr, wl, wr;
    logic [63:0] inc;
    int unsigned n;
    flg_pkg::out_t r;
    dl = longint'(s.left_in);
    dr = longint'(s.right_in);
    rate = longint'(s.lfo_rate);
    depth = longint'(s.sweep_depth);
    fb = longint'(s.feedback_gain);
    mix = longint'(s.wet_blend);
    if (rate < 10) rate = 10;
    if (rate > 10000) rate = 10000;
    if (depth > 32768) depth = 32768;
    if (fb > 31130) fb = 31130;
    if (fb < -31130) fb = -31130;
    if (mix > 32768) mix = 32768;
    inc = (64'(rate) << 32) / 64'd48000000;
    phase_acc = phase_acc + inc[31:0];
    lfo = lfo_sine(phase_acc) + 32768;
    target = (min_dly_reg << 16) + ((depth * sweep_reg * lfo) >> 15);
    smooth_dly = (smooth_dly + rshift_round(coeff_reg * (target - smooth_dly), 16))
                 & 64'h3FF_FFFF;
    rd = smooth_dly;
    if (rd < (longint'(1) << 16)) rd = longint'(1) << 16;
    if (rd > (longint'(510) << 16)) rd = longint'(510) << 16;
    n = 32'(rd >> 16);
    f = rd & 64'hFFFF;
    yl = tap_read(1'b0, n, f);
    yr = tap_read(1'b1, n, f);
    mem_l[wr_ptr] = clamp24(dl + rshift_round(fb * yl, 15));
    mem_r[wr_ptr] = clamp24(dr + rshift_round(fb * yr, 15));
    wl = rshift_round(23170 * (dl + yl), 15);
    wr = rshift_round(23170 * (dr + yr), 15);
    r.left_out = 24'(clamp24(dl + rshift_round(mix * (wl - dl), 15)));
    r.right_out = 24'(clamp24(dr + rshift_round(mix * (wr - dr), 15)));
    wr_ptr = (wr_ptr + 1) & 511;
    return r;
  endfunction

  task automatic send_sample(flg_pkg::in_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= s;
    do @(posedge clk); while (!in_ready);
    expected_mix.push_back(flange_sample(s));
  endtask

  task automatic write_reg(flg_pkg::cfg_idx_t idx, logic [flg_pkg::CfgDataW-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    case (idx)
      flg_pkg::CFG_COEFF:     coeff_reg = longint'(val);
      flg_pkg::CFG_MIN_DELAY: min_dly_reg = longint'(val & 16'h7F);
      flg_pkg::CFG_MAX_SWEEP: sweep_reg = longint'(val & 16'h1FF);
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_mix.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic flg_pkg::in_t random_sample(bit in_range);
    flg_pkg::in_t s;
    logic [127:0] bits;
    bits = {$urandom, $urandom, $urandom, $urandom};
    s = bits[InW-1:0];
    if (in_range) begin
      s.lfo_rate = 14'($urandom_range(10000, 10));
      s.sweep_depth = 16'($urandom_range(32768));
      s.feedback_gain = 16'($urandom_range(62260) - 31130);
      s.wet_blend = 16'($urandom_range(32768));
    end
    return s;
  endfunction

  initial begin
    forever begin
      @(hold_go);
      holding <= 1'b1;
      repeat (300) @(posedge clk);
      holding <= 1'b0;
    end
  end

  always @(posedge clk) begin
    flg_pkg::out_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_mix.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result transaction: %h", out_data);
      end else begin
        e = expected_mix.pop_front();
        if (out_data.left_out !== e.left_out || out_data.right_out !== e.right_out) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected L=%0d R=%0d, got L=%0d R=%0d",
                     e.left_out, e.right_out, out_data.left_out, out_data.right_out);
        end
      end
    end
    out_ready <= !holding && ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic test_extremes();
    flg_pkg::in_t s;
    s = '{24'sh7FFFFF, 24'sh7FFFFF, 14'd16383, 16'hFFFF, 16'sh7FFF, 16'hFFFF};
    send_sample(s);
    s = '{24'sh800000, 24'sh800000, 14'd0, 16'h0000, 16'sh8000, 16'h0000};
    send_sample(s);
    s = '{24'sh800000, 24'sh7FFFFF, 14'd9, 16'h8000, -16'sd31130, 16'h8000};
    send_sample(s);
    s = '{24'sh7FFFFF, 24'sh800000, 14'd10000, 16'h8001, 16'sd31131, 16'h8001};
    send_sample(s);
    for (int i = 0; i < 6; i++) send_sample(random_sample(i[0]));
    wait_idle();
  endtask

  task automatic test_short_delay_clamp();
    write_reg(flg_pkg::CFG_COEFF, 16'hFFFF);
    write_reg(flg_pkg::CFG_MIN_DELAY, 16'd0);
    write_reg(flg_pkg::CFG_MAX_SWEEP, 16'd0);
    write_reg(flg_pkg::cfg_idx_t'(2'd3), 16'h1234);
    for (int i = 0; i < 8; i++) send_sample(random_sample(1'b1));
    wait_idle();
  endtask

  task automatic test_long_delay_clamp();
    flg_pkg::in_t s;
    write_reg(flg_pkg::CFG_MIN_DELAY, 16'hFFFF);
    write_reg(flg_pkg::CFG_MAX_SWEEP, 16'hFFFF);
    for (int i = 0; i < 8; i++) begin
      s = random_sample(1'b1);
      s.sweep_depth = 16'h8000;
      send_sample(s);
    end
    wait_idle();
  endtask

  task automatic test_random();
    for (int p = 0; p < 4; p++) begin
      write_reg(flg_pkg::CFG_COEFF, (p == 0) ? 16'd679 : 16'($urandom));
      write_reg(flg_pkg::CFG_MIN_DELAY, (p == 1) ? 16'd127 : 16'($urandom_range(127)));
      write_reg(flg_pkg::CFG_MAX_SWEEP, (p == 1) ? 16'd480 : 16'($urandom_range(480)));
      send_idle_pct = (p == 2) ? 0 : 38;
      recv_idle_pct = (p == 2) ? 0 : 38;
      for (int i = 0; i < 85; i++) send_sample(random_sample($urandom_range(9) != 0));
      wait_idle();
    end
    send_idle_pct = 38;
    recv_idle_pct = 38;
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    -> hold_go;
    for (int i = 0; i < 12; i++) send_sample(random_sample(1'b1));
    send_idle_pct = 38;
    wait_idle();
  endtask

  initial begin
    for (int i = 0; i < 512; i++) begin
      mem_l[i] = 0;
      mem_r[i] = 0;
    end
    wr_ptr = 0;
    phase_acc = '0;
    smooth_dly = longint'(96) << 16;
    coeff_reg = 679;
    min_dly_reg = 24;
    sweep_reg = 360;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_short_delay_clamp();
    test_long_delay_clamp();
    test_random();
    test_backpressure();
    if (mismatches == 0 && expected_mix.size() == 0) begin
      $display("stereo_flanger test passed");
    end else begin
      $display("stereo_flanger test failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("stereo_flanger test failed");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/flg_pkg.sv
rtl/flg_ram.sv
rtl/flg_queue.sv
rtl/flg_front.sv
rtl/flg_core.sv
rtl/stereo_flanger.sv
tb/sv/stereo_flanger_test.sv
